/* sv/tim_texture_to_rgba_defines.svh */
// Assertion macros for the texture decoder checks.
`ifndef TIM_TEXTURE_TO_RGBA_DEFINES_SVH
`define TIM_TEXTURE_TO_RGBA_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TTR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tim_texture_to_rgba check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TTR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tim_texture_to_rgba check failed");

`endif

/* sv/ttr_pkg.sv */
package ttr_pkg;

  localparam int ByteW    = 8;
  localparam int ColorW   = 16;
  localparam int CountW   = 24;
  localparam int SizeW    = 9;
  localparam int ChanW    = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;
  localparam int StepW    = 3;

  typedef enum logic [1:0] {
    ACT_PAL_WRITE = 2'd0,
    ACT_PIXEL     = 2'd1,
    ACT_START     = 2'd2
  } ttr_action_e;

  typedef enum logic [1:0] {
    MODE_IDX4  = 2'd0,
    MODE_IDX8  = 2'd1,
    MODE_RGB15 = 2'd2,
    MODE_RGB24 = 2'd3
  } ttr_mode_e;

  typedef enum logic [1:0] {
    IDX_LO_NIBBLE = 2'd0,
    IDX_HI_NIBBLE = 2'd1,
    IDX_BYTE      = 2'd2
  } ttr_idx_sel_e;

  localparam logic [CfgIdxW-1:0] CFG_PIXEL_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PALETTE_SIZE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PIXEL_COUNT  = 2'd2;

  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_ONE  = 2'd1;
  localparam logic [1:0] PHASE_TWO  = 2'd2;

  typedef struct packed {
    logic         load_item;
    logic         pal_write;
    logic         clear_img;
    logic         held_lo;
    logic         held_hi;
    logic         phase_clr;
    logic         mod_load;
    ttr_idx_sel_e idx_sel;
    logic         mod_step;
    logic         ram_rd;
    logic         rd_rem;
    logic         out_load;
  } ttr_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    ttr_mode_e  mode;
    logic [1:0] phase;
    logic       img_done;
    logic       pal_empty;
    logic       idx_fast;
    logic       mod_last;
    logic       more_pix;
    logic       out_free;
  } ttr_sts_t;

  function automatic logic [ChanW-1:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

endpackage

/* sv/ttr_ram.sv */
module ttr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ttr_ctrl.sv */
module ttr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ttr_pkg::ttr_sts_t sts_i,
  output ttr_pkg::ttr_cmd_t cmd_o
);
  import ttr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_MOD,
    S_DIV,
    S_RD,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   hi_q, hi_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    hi_d    = hi_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_IDLE;
        hi_d    = 1'b0;
        case (sts_i.action)
          ACT_PAL_WRITE: cmd_o.pal_write = 1'b1;
          ACT_START:     cmd_o.clear_img = 1'b1;
          ACT_PIXEL: begin
            if (!sts_i.img_done) begin
              case (sts_i.mode)
                MODE_IDX4, MODE_IDX8: begin
                  cmd_o.phase_clr = 1'b1;
                  cmd_o.mod_load  = 1'b1;
                  cmd_o.idx_sel   = (sts_i.mode == MODE_IDX4) ? IDX_LO_NIBBLE : IDX_BYTE;
                  state_d         = sts_i.pal_empty ? S_EMIT : S_MOD;
                end
                MODE_RGB15: begin
                  if (sts_i.phase == PHASE_NONE) begin
                    cmd_o.held_lo = 1'b1;
                  end else begin
                    cmd_o.phase_clr = 1'b1;
                    state_d         = S_EMIT;
                  end
                end
                default: begin
                  if (sts_i.phase == PHASE_NONE) begin
                    cmd_o.held_lo = 1'b1;
                  end else if (sts_i.phase == PHASE_ONE) begin
                    cmd_o.held_hi = 1'b1;
                  end else begin
                    cmd_o.phase_clr = 1'b1;
                    state_d         = S_EMIT;
                  end
                end
              endcase
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_MOD: begin
        if (sts_i.idx_fast) begin
          cmd_o.ram_rd = 1'b1;
          state_d      = S_EMIT;
        end else begin
          cmd_o.mod_step = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.ram_rd = 1'b1;
        cmd_o.rd_rem = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.mode == MODE_IDX4 && !hi_q && sts_i.more_pix) begin
            cmd_o.mod_load = 1'b1;
            cmd_o.idx_sel  = IDX_HI_NIBBLE;
            hi_d           = 1'b1;
            state_d        = sts_i.pal_empty ? S_EMIT : S_MOD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hi_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      hi_q    <= hi_d;
    end
  end

endmodule

/* sv/ttr_dp.sv */
module ttr_dp #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [1:0]                      action_i,
  input  logic [ttr_pkg::ByteW-1:0]       palette_index_i,
  input  logic [ttr_pkg::ColorW-1:0]      palette_color_i,
  input  logic [ttr_pkg::ByteW-1:0]       data_byte_i,
  input  logic                            cfg_we_i,
  input  logic [ttr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ttr_pkg::CfgDataW-1:0]    cfg_data_i,
  input  ttr_pkg::ttr_cmd_t               cmd_i,
  output ttr_pkg::ttr_sts_t               sts_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ttr_pkg::ChanW-1:0]       red_o,
  output logic [ttr_pkg::ChanW-1:0]       green_o,
  output logic [ttr_pkg::ChanW-1:0]       blue_o,
  output logic [ttr_pkg::ChanW-1:0]       alpha_o,
  output logic                            last_pixel_o,
  output logic                            no_palette_o
);
  import ttr_pkg::*;

  localparam int              AddrW  = $clog2(PALETTE_DEPTH);
  localparam logic [SizeW-1:0] DepthN = SizeW'(PALETTE_DEPTH);

  logic [1:0]        action_q;
  logic [ByteW-1:0]  pidx_q;
  logic [ColorW-1:0] pcol_q;
  logic [ByteW-1:0]  byte_q;

  ttr_mode_e         mode_q;
  logic [SizeW-1:0]  size_q;
  logic [CountW-1:0] count_q;

  logic [ColorW-1:0] held_q;
  logic [1:0]        phase_q;
  logic [CountW-1:0] done_q;

  logic [ByteW-1:0]  dvd_q;
  logic [SizeW-1:0]  rem_q;
  logic [StepW-1:0]  cnt_q;

  logic              out_valid_q;
  logic [ChanW-1:0]  red_q, green_q, blue_q, alpha_q;
  logic              last_q, nopal_q;

  logic [SizeW-1:0]  n_eff;
  logic [SizeW-1:0]  rem_shift, rem_d;
  logic [ByteW-1:0]  idx_next;
  logic [CountW-1:0] done_inc;
  logic              pal_we;
  logic [AddrW-1:0]  raddr;
  logic [ColorW-1:0] ram_rdata;
  logic [ColorW-1:0] word;
  logic [ChanW-1:0]  pix_r, pix_g, pix_b, pix_a;
  logic              pix_np;
  logic              indexed;

  assign n_eff     = (size_q > DepthN) ? DepthN : size_q;
  assign rem_shift = {rem_q[SizeW-2:0], dvd_q[ByteW-1]};
  assign rem_d     = (rem_shift >= n_eff) ? rem_shift - n_eff : rem_shift;
  assign done_inc  = done_q + CountW'(1);
  assign indexed   = (mode_q == MODE_IDX4) || (mode_q == MODE_IDX8);
  assign pal_we    = cmd_i.pal_write && ({1'b0, pidx_q} < DepthN);
  assign raddr     = cmd_i.rd_rem ? rem_q[AddrW-1:0] : dvd_q[AddrW-1:0];

  always_comb begin
    case (cmd_i.idx_sel)
      IDX_LO_NIBBLE: idx_next = {4'h0, byte_q[3:0]};
      IDX_HI_NIBBLE: idx_next = {4'h0, byte_q[7:4]};
      default:       idx_next = byte_q;
    endcase
  end

  ttr_ram #(
    .WIDTH(ColorW),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pidx_q[AddrW-1:0]),
    .wdata_i (pcol_q),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    word   = (mode_q == MODE_RGB15) ? {byte_q, held_q[ByteW-1:0]} : ram_rdata;
    pix_r  = expand5(word[4:0]);
    pix_g  = expand5(word[9:5]);
    pix_b  = expand5(word[14:10]);
    pix_a  = (word == '0) ? '0 : '1;
    pix_np = 1'b0;
    if (mode_q == MODE_RGB24) begin
      pix_r = held_q[ByteW-1:0];
      pix_g = held_q[ColorW-1:ByteW];
      pix_b = byte_q;
      pix_a = '1;
    end else if (indexed && n_eff == '0) begin
      pix_r  = '0;
      pix_g  = '0;
      pix_b  = '0;
      pix_a  = '0;
      pix_np = 1'b1;
    end
  end

  always_comb begin
    sts_o.action    = action_q;
    sts_o.mode      = mode_q;
    sts_o.phase     = phase_q;
    sts_o.img_done  = (done_q >= count_q);
    sts_o.pal_empty = (n_eff == '0);
    sts_o.idx_fast  = ({1'b0, dvd_q} < n_eff);
    sts_o.mod_last  = (cnt_q == '1);
    sts_o.more_pix  = ({1'b0, done_q} + (CountW + 1)'(1)) < {1'b0, count_q};
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // item beat, remainder unit and pixel payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q <= action_i;
      pidx_q   <= palette_index_i;
      pcol_q   <= palette_color_i;
      byte_q   <= data_byte_i;
    end
    if (cmd_i.mod_load) begin
      dvd_q <= idx_next;
      rem_q <= '0;
    end else if (cmd_i.mod_step) begin
      dvd_q <= {dvd_q[ByteW-2:0], 1'b0};
      rem_q <= rem_d;
    end
    if (cmd_i.out_load) begin
      red_q   <= pix_r;
      green_q <= pix_g;
      blue_q  <= pix_b;
      alpha_q <= pix_a;
      last_q  <= (done_inc == count_q);
      nopal_q <= pix_np;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RGB15;
      size_q      <= '0;
      count_q     <= '0;
      held_q      <= '0;
      phase_q     <= PHASE_NONE;
      done_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PIXEL_MODE:   mode_q  <= ttr_mode_e'(cfg_data_i[1:0]);
          CFG_PALETTE_SIZE: size_q  <= cfg_data_i[SizeW-1:0];
          CFG_PIXEL_COUNT:  count_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clear_img) begin
        held_q  <= '0;
        phase_q <= PHASE_NONE;
        done_q  <= '0;
      end else begin
        if (cmd_i.held_lo) begin
          held_q  <= {{(ColorW - ByteW){1'b0}}, byte_q};
          phase_q <= PHASE_ONE;
        end else if (cmd_i.held_hi) begin
          held_q[ColorW-1:ByteW] <= byte_q;
          phase_q                <= PHASE_TWO;
        end else if (cmd_i.phase_clr) begin
          phase_q <= PHASE_NONE;
        end
        if (cmd_i.out_load) begin
          done_q <= done_inc;
        end
      end
      if (cmd_i.mod_load) begin
        cnt_q <= '0;
      end else if (cmd_i.mod_step) begin
        cnt_q <= cnt_q + StepW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign alpha_o      = alpha_q;
  assign last_pixel_o = last_q;
  assign no_palette_o = nopal_q;

endmodule

/* sv/tim_texture_to_rgba.sv */
// Flow: a byte beat is registered, then dispatched. Palette writes, starts and held bytes
// end there; a direct or empty-palette pixel goes on to the output register, an indexed
// pixel below the palette size reads the palette first, and otherwise the 8-step
// remainder unit runs before the read. A new beat is taken only when idle; the second
// pixel of a 4-bit byte repeats the lookup, and output stalls keep the block busy.
// Reset: asynchronous; control, counters and config take reset values, palette is kept.
module tim_texture_to_rgba #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic [ttr_pkg::ByteW-1:0]    palette_index_i,
  input  logic [ttr_pkg::ColorW-1:0]   palette_color_i,
  input  logic [ttr_pkg::ByteW-1:0]    data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ttr_pkg::ChanW-1:0]    red_o,
  output logic [ttr_pkg::ChanW-1:0]    green_o,
  output logic [ttr_pkg::ChanW-1:0]    blue_o,
  output logic [ttr_pkg::ChanW-1:0]    alpha_o,
  output logic                         last_pixel_o,
  output logic                         no_palette_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ttr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ttr_pkg::CfgDataW-1:0] cfg_data_i
);
  import ttr_pkg::*;

  ttr_cmd_t cmd;
  ttr_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ttr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ttr_dp #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .action_i        (action_i),
    .palette_index_i (palette_index_i),
    .palette_color_i (palette_color_i),
    .data_byte_i     (data_byte_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .alpha_o         (alpha_o),
    .last_pixel_o    (last_pixel_o),
    .no_palette_o    (no_palette_o)
  );

endmodule

/* sv/tim_texture_to_rgba_chk.sv */
`include "tim_texture_to_rgba_defines.svh"

module tim_texture_to_rgba_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [ttr_pkg::ChanW-1:0]    red_o,
  input logic [ttr_pkg::ChanW-1:0]    green_o,
  input logic [ttr_pkg::ChanW-1:0]    blue_o,
  input logic [ttr_pkg::ChanW-1:0]    alpha_o,
  input logic                         no_palette_o
);

  // hold a stalled output beat
  `TTR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // drop everything but the flag on an empty palette
  `TTR_ASSERT(a_nopal_black, out_valid_o && no_palette_o,
              red_o == '0 && green_o == '0 && blue_o == '0 && alpha_o == '0)

  `TTR_ASSERT(a_alpha_code, out_valid_o, alpha_o == '0 || alpha_o == '1)

  // one input beat at a time
  `TTR_ASSERT_NEXT(a_busy_after_beat, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind tim_texture_to_rgba tim_texture_to_rgba_chk u_chk (.*);

/* dv/tb_top.sv */
module tb_top;
  import ttr_pkg::*;

  localparam int          CycleLimit = 600000;
  localparam int          DrainWait  = 40;
  localparam int          IdlePct    = 29;
  localparam logic [1:0]  ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  act;
    logic [7:0]  idx;
    logic [15:0] color;
    logic [7:0]  data;
  } beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
    logic       nopal;
  } pixel_t;

  logic        clk_i;
  logic        rst_ni          = 1'b1;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i        = '0;
  logic [7:0]  palette_index_i = '0;
  logic [15:0] palette_color_i = '0;
  logic [7:0]  data_byte_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [7:0]  red_o, green_o, blue_o, alpha_o;
  logic        last_pixel_o, no_palette_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i     = '0;
  logic [23:0] cfg_data_i      = '0;

  tim_texture_to_rgba u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .palette_index_i(palette_index_i),
    .palette_color_i(palette_color_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .last_pixel_o   (last_pixel_o),
    .no_palette_o   (no_palette_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  beat_t       pending_beats[$];
  pixel_t      expected_pixels[$];
  beat_t       cur;
  logic        in_fire   = 1'b0;
  bit          calm      = 1'b0;
  int          err_cnt   = 0;
  int          pix_cnt   = 0;
  int          sent_cnt  = 0;
  int unsigned cycle_cnt = 0;

  logic [15:0] pal_mem[256];
  logic [15:0] held_q     = '0;
  logic [1:0]  phase_q    = PHASE_NONE;
  logic [23:0] done_q     = '0;
  ttr_mode_e   mode_sh    = MODE_RGB15;
  logic [8:0]  psize_sh   = '0;
  logic [23:0] pcount_sh  = '0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("ERROR: %s", msg);
    err_cnt++;
  endtask

  function automatic logic [7:0] widen5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic pixel_t word_pixel(logic [15:0] w);
    pixel_t p;
    p.red   = widen5(w[4:0]);
    p.green = widen5(w[9:5]);
    p.blue  = widen5(w[14:10]);
    p.alpha = (w == 16'h0) ? 8'd0 : 8'd255;
    p.last  = 1'b0;
    p.nopal = 1'b0;
    return p;
  endfunction

  task automatic push_pixel(pixel_t p);
    done_q = done_q + 24'd1;
    p.last = (done_q == pcount_sh);
    expected_pixels = {expected_pixels, p};
  endtask

  task automatic lookup_pixel(logic [7:0] idx);
    pixel_t      p;
    int unsigned n;
    n = (psize_sh > 9'd256) ? 256 : psize_sh;
    if (n == 0) begin
      p = '0;
      p.nopal = 1'b1;
    end else begin
      p = word_pixel(pal_mem[idx % n]);
    end
    push_pixel(p);
  endtask

  task automatic decode_beat(beat_t b);
    pixel_t p;
    case (b.act)
      ACT_PAL_WRITE: pal_mem[b.idx] = b.color;
      ACT_START: begin
        held_q  = '0;
        phase_q = PHASE_NONE;
        done_q  = '0;
      end
      ACT_PIXEL: begin
        if (done_q < pcount_sh) begin
          case (mode_sh)
            MODE_IDX4: begin
              phase_q = PHASE_NONE;
              lookup_pixel({4'h0, b.data[3:0]});
              if (done_q < pcount_sh) lookup_pixel({4'h0, b.data[7:4]});
            end
            MODE_IDX8: begin
              phase_q = PHASE_NONE;
              lookup_pixel(b.data);
            end
            MODE_RGB15: begin
              if (phase_q == PHASE_NONE) begin
                held_q  = {8'h0, b.data};
                phase_q = PHASE_ONE;
              end else begin
                phase_q = PHASE_NONE;
                push_pixel(word_pixel({b.data, held_q[7:0]}));
              end
            end
            default: begin
              if (phase_q == PHASE_NONE) begin
                held_q  = {8'h0, b.data};
                phase_q = PHASE_ONE;
              end else if (phase_q == PHASE_ONE) begin
                held_q  = {b.data, held_q[7:0]};
                phase_q = PHASE_TWO;
              end else begin
                phase_q = PHASE_NONE;
                p.red   = held_q[7:0];
                p.green = held_q[15:8];
                p.blue  = b.data;
                p.alpha = 8'd255;
                p.last  = 1'b0;
                p.nopal = 1'b0;
                push_pixel(p);
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("pixel %0d %s got %h want %h", pix_cnt, name, got, want));
  endtask

  // drive input beats and output stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          cur = pending_beats.pop_front();
          in_valid_i      <= 1'b1;
          action_i        <= cur.act;
          palette_index_i <= cur.idx;
          palette_color_i <= cur.color;
          data_byte_i     <= cur.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  // check result beats, track config and input beats
  always @(posedge clk_i) begin
    pixel_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel %0d arrived with none expected", pix_cnt));
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", red_o, want.red);
        check_field("green", green_o, want.green);
        check_field("blue", blue_o, want.blue);
        check_field("alpha", alpha_o, want.alpha);
        check_field("last_pixel", {7'h0, last_pixel_o}, {7'h0, want.last});
        check_field("no_palette", {7'h0, no_palette_o}, {7'h0, want.nopal});
      end
      pix_cnt++;
    end
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PIXEL_MODE:   mode_sh   = ttr_mode_e'(cfg_data_i[1:0]);
        CFG_PALETTE_SIZE: psize_sh  = cfg_data_i[8:0];
        CFG_PIXEL_COUNT:  pcount_sh = cfg_data_i;
        default: ;
      endcase
    end
    if (in_valid_i && !in_stall_o)
      decode_beat({action_i, palette_index_i, palette_color_i, data_byte_i});
    in_fire <= in_valid_i && !in_stall_o;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_beat(logic [1:0] a, logic [7:0] d);
    beat_t b;
    b.act   = a;
    b.idx   = 8'($urandom);
    b.color = 16'($urandom);
    b.data  = d;
    pending_beats = {pending_beats, b};
    sent_cnt++;
  endtask

  task automatic push_pal(logic [7:0] i, logic [15:0] c);
    beat_t b;
    b.act   = ACT_PAL_WRITE;
    b.idx   = i;
    b.color = c;
    b.data  = 8'($urandom);
    pending_beats = {pending_beats, b};
    sent_cnt++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(ttr_mode_e m, logic [8:0] sz, logic [23:0] cnt);
    write_reg(CFG_PIXEL_MODE, {22'h0, m});
    write_reg(CFG_PALETTE_SIZE, {15'h0, sz});
    write_reg(CFG_PIXEL_COUNT, cnt);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_beats.size() != 0 || in_valid_i || in_stall_o ||
           expected_pixels.size() != 0);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  initial begin
    int          phase_no;
    int          n;
    int          r;
    int          need;
    logic [23:0] cnt;
    #1 rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill the whole palette so no indexed read hits an unwritten entry
    for (int i = 0; i < 256; i++) begin
      case (i)
        0:       push_pal(8'(i), 16'h0000);
        1:       push_pal(8'(i), 16'hffff);
        2:       push_pal(8'(i), 16'h8000);
        3:       push_pal(8'(i), 16'h7fff);
        default: push_pal(8'(i), 16'($urandom));
      endcase
    end
    push_beat(ACT_UNUSED, 8'h5a);
    wait_idle();

    set_regs(MODE_RGB15, 9'd256, 24'd3);
    push_beat(ACT_START, 8'h00);
    push_beat(ACT_PIXEL, 8'h00);
    push_beat(ACT_PIXEL, 8'h00);
    push_beat(ACT_PIXEL, 8'hff);
    push_beat(ACT_PIXEL, 8'hff);
    push_beat(ACT_PIXEL, 8'h00);
    push_beat(ACT_PIXEL, 8'h80);
    push_beat(ACT_PIXEL, 8'h12);
    wait_idle();

    set_regs(MODE_RGB24, 9'd256, 24'd1);
    push_beat(ACT_START, 8'h00);
    push_beat(ACT_PIXEL, 8'h00);
    push_beat(ACT_PIXEL, 8'h00);
    push_beat(ACT_PIXEL, 8'h00);
    push_beat(ACT_PIXEL, 8'hff);
    wait_idle();

    set_regs(MODE_IDX4, 9'd256, 24'd3);
    push_beat(ACT_START, 8'h00);
    push_beat(ACT_PIXEL, 8'h10);
    push_beat(ACT_PIXEL, 8'h32);
    wait_idle();

    set_regs(MODE_IDX8, 9'd0, 24'd2);
    push_beat(ACT_START, 8'h00);
    push_beat(ACT_PIXEL, 8'hff);
    push_beat(ACT_PIXEL, 8'h00);
    wait_idle();

    set_regs(MODE_IDX8, 9'd1, 24'd0);
    push_beat(ACT_START, 8'h00);
    push_beat(ACT_PIXEL, 8'h55);
    wait_idle();

    // switch mode with bytes held mid-pixel
    set_regs(MODE_RGB24, 9'd256, 24'd4);
    push_beat(ACT_START, 8'h00);
    push_beat(ACT_PIXEL, 8'h11);
    push_beat(ACT_PIXEL, 8'h22);
    wait_idle();
    write_reg(CFG_PIXEL_MODE, {22'h0, MODE_RGB15});
    push_beat(ACT_PIXEL, 8'h33);
    push_beat(ACT_PIXEL, 8'h44);
    wait_idle();
    write_reg(CFG_PIXEL_MODE, {22'h0, MODE_IDX8});
    push_beat(ACT_PIXEL, 8'hff);
    push_beat(ACT_UNUSED, 8'h07);
    wait_idle();

    phase_no = 0;
    while (sent_cnt < 1950) begin
      phase_no++;
      calm = (phase_no >= 8 && phase_no < 14);
      if ($urandom_range(9) < 7)
        write_reg(CFG_PIXEL_MODE, {22'h0, 2'($urandom_range(3))});
      if ($urandom_range(9) < 7) begin
        r = $urandom_range(99);
        if (r < 12)      write_reg(CFG_PALETTE_SIZE, 24'd0);
        else if (r < 24) write_reg(CFG_PALETTE_SIZE, 24'd256);
        else if (r < 32) write_reg(CFG_PALETTE_SIZE, 24'd1);
        else             write_reg(CFG_PALETTE_SIZE, 24'($urandom_range(2, 255)));
      end
      if ($urandom_range(9) < 7) begin
        r = $urandom_range(99);
        if (r < 5)       cnt = 24'd0;
        else if (r < 10) cnt = 24'hffffff;
        else if (r < 15) cnt = 24'd1;
        else             cnt = 24'($urandom_range(2, 40));
        write_reg(CFG_PIXEL_COUNT, cnt);
      end
      if ($urandom_range(99) < 85) push_beat(ACT_START, 8'($urandom));
      case (mode_sh)
        MODE_IDX4:  need = (pcount_sh + 1) / 2;
        MODE_IDX8:  need = pcount_sh;
        MODE_RGB15: need = 2 * pcount_sh;
        default:    need = 3 * pcount_sh;
      endcase
      if (pcount_sh > 24'd40) n = $urandom_range(20, 90);
      else                    n = need + $urandom_range(0, 3);
      if (n > 120) n = 120;
      for (int j = 0; j < n; j++) begin
        r = $urandom_range(99);
        if (r < 84)      push_beat(ACT_PIXEL, 8'($urandom));
        else if (r < 90) push_pal(8'($urandom), 16'($urandom));
        else if (r < 94) push_beat(ACT_START, 8'($urandom));
        else if (r < 97) push_beat(ACT_UNUSED, 8'($urandom));
        else             push_beat(ACT_PIXEL, ($urandom_range(1) != 0) ? 8'hff : 8'h00);
      end
      wait_idle();
    end
    calm = 1'b0;

    wait_idle();
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
